// File: src/asm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asm_pkg
// Shared types and constants for the accelerometer scale and magnitude block.
// ----------------------------------------------------------------------------
package asm_pkg;

   localparam int AXIS_W  = 24;
   localparam int SCALE_W = 16;
   localparam int CSR_W   = 24;
   localparam int IDX_W   = 2;
   localparam int SUM_W   = 2 * AXIS_W;
   localparam int REM_W   = AXIS_W + 2;
   localparam int CELLS   = AXIS_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd31503;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SCALE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_OFFSET_X = 2'd1;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y = 2'd2;
   localparam logic [IDX_W-1:0] REG_OFFSET_Z = 2'd3;

   typedef struct packed {
      logic [7:0] x_low;
      logic [7:0] x_high;
      logic [7:0] y_low;
      logic [7:0] y_high;
      logic [7:0] z_low;
      logic [7:0] z_high;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic        [AXIS_W-1:0] magnitude;
   } rsp_type;

   // word handed along the square root chain
   typedef struct packed {
      logic        [SUM_W-1:0]  rad;
      logic        [REM_W-1:0]  rem;
      logic        [AXIS_W-1:0] root;
      logic signed [AXIS_W-1:0] ax;
      logic signed [AXIS_W-1:0] ay;
      logic signed [AXIS_W-1:0] az;
   } cell_type;

endpackage : asm_pkg
`default_nettype wire

// File: src/asm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asm_front
// Four elastic stages: scale product, shift/offset/saturate, squares, sum.
// ----------------------------------------------------------------------------
module asm_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  asm_pkg::req_type           in_data,
   input  wire  [asm_pkg::SCALE_W-1:0] scale,
   input  wire  [asm_pkg::AXIS_W-1:0] offset_x,
   input  wire  [asm_pkg::AXIS_W-1:0] offset_y,
   input  wire  [asm_pkg::AXIS_W-1:0] offset_z,
   output logic                       out_valid,
   input  wire                        out_ready,
   output asm_pkg::cell_type          out_data
);
   import asm_pkg::*;

   logic [3:0] valid_ff;
   logic [3:0] adv;

   logic signed [31:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [31:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [AXIS_W-1:0] ax_in, ay_in, az_in;
   logic signed [AXIS_W-1:0] ax2_ff, ay2_ff, az2_ff;
   logic [SUM_W-2:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_W-2:0] sq_x_in, sq_y_in, sq_z_in;
   cell_type sum_ff, sum_in;

   // advance a stage when empty or when the next one advances
   assign adv[3]   = !valid_ff[3] || out_ready;
   assign adv[2]   = !valid_ff[2] || adv[3];
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   function automatic logic signed [31:0] scale_mul(input logic [7:0] lo,
                                                    input logic [7:0] hi,
                                                    input logic [SCALE_W-1:0] s);
      logic signed [32:0] cnt;
      logic signed [32:0] scl;
      logic signed [32:0] p;
      cnt = $signed({{17{hi[7]}}, hi, lo});
      scl = $signed({17'd0, s});
      p   = cnt * scl;
      return p[31:0];
   endfunction

   function automatic logic signed [AXIS_W-1:0] offset_sat(input logic signed [31:0] p,
                                                           input logic [AXIS_W-1:0] off);
      logic signed [AXIS_W:0] d;
      d = $signed({p[31], p[31:8]}) - $signed({off[AXIS_W-1], off});
      if (d[AXIS_W] != d[AXIS_W-1]) begin
         return d[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
      end
      return d[AXIS_W-1:0];
   endfunction

   function automatic logic [SUM_W-2:0] square(input logic signed [AXIS_W-1:0] a);
      logic signed [SUM_W-1:0] q;
      q = a * a;
      return q[SUM_W-2:0];
   endfunction

   // stage logic
   always_comb begin
      prod_x_in = scale_mul(in_data.x_low, in_data.x_high, scale);
      prod_y_in = scale_mul(in_data.y_low, in_data.y_high, scale);
      prod_z_in = scale_mul(in_data.z_low, in_data.z_high, scale);
      ax_in     = offset_sat(prod_x_ff, offset_x);
      ay_in     = offset_sat(prod_y_ff, offset_y);
      az_in     = offset_sat(prod_z_ff, offset_z);
      sq_x_in   = square(ax_ff);
      sq_y_in   = square(ay_ff);
      sq_z_in   = square(az_ff);
      sum_in.rad  = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
      sum_in.rem  = '0;
      sum_in.root = '0;
      sum_in.ax   = ax2_ff;
      sum_in.ay   = ay2_ff;
      sum_in.az   = az2_ff;
   end

   // hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
         if (adv[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
      if (adv[1] && valid_ff[0]) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
      end
      if (adv[2] && valid_ff[1]) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
         ax2_ff  <= ax_ff;
         ay2_ff  <= ay_ff;
         az2_ff  <= az_ff;
      end
      if (adv[3] && valid_ff[2]) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = sum_ff;

endmodule : asm_front
`default_nettype wire

// File: src/asm_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asm_sqrt_cell
// One digit step of the integer square root, with an elastic register.
// ----------------------------------------------------------------------------
module asm_sqrt_cell (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  asm_pkg::cell_type in_data,
   output logic              out_valid,
   input  wire               out_ready,
   output asm_pkg::cell_type out_data
);
   import asm_pkg::*;

   logic     valid_ff;
   cell_type data_ff, data_in;
   logic     adv;
   logic [REM_W+1:0] rem_w;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem_w   = {in_data.rem, in_data.rad[SUM_W-1 -: 2]};
      trial   = {2'b00, in_data.root, 2'b01};
      diff    = rem_w - trial;
      data_in = in_data;
      data_in.rad = {in_data.rad[SUM_W-3:0], 2'b00};
      if (rem_w >= trial) begin
         data_in.rem  = diff[REM_W-1:0];
         data_in.root = {in_data.root[AXIS_W-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_w[REM_W-1:0];
         data_in.root = {in_data.root[AXIS_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule : asm_sqrt_cell
`default_nettype wire

// File: src/accel_sample_scale_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_sample_scale_magnitude
// Scales a raw three-axis accelerometer burst and forms its vector magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one six-byte burst per transaction (req_valid, req_stall).
//   rsp_* returns the scaled axes and the magnitude, one transaction for each
//   burst, in order. csr_* writes scale and the three offsets; write only
//   while no burst is in flight.
//   Four arithmetic stages (scale product, offset and saturation, squares,
//   sum) feed a chain of 24 root cells, one root bit per cell. Throughput is
//   one burst per cycle while rsp_stall is low; every stage and cell is an
//   elastic register, so bubbles close up and a new burst is taken while a
//   finished result waits.
//   When rsp_stall is held, the chain fills and then raises req_stall.
//   Reset empties the pipeline and sets scale to 31503, offsets to zero.
// ----------------------------------------------------------------------------
module accel_sample_scale_magnitude (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  asm_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output asm_pkg::rsp_type          rsp_data,
   input  wire                       csr_wr_en,
   input  wire  [asm_pkg::IDX_W-1:0] csr_index,
   input  wire  [asm_pkg::CSR_W-1:0] csr_wr_data
);
   import asm_pkg::*;

   logic [SCALE_W-1:0] scale_ff;
   logic [AXIS_W-1:0]  offset_x_ff, offset_y_ff, offset_z_ff;

   logic     front_ready;
   logic     chain_valid [CELLS+1];
   logic     chain_ready [CELLS+1];
   cell_type chain_data  [CELLS+1];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SCALE:    scale_ff    <= csr_wr_data[SCALE_W-1:0];
            REG_OFFSET_X: offset_x_ff <= csr_wr_data[AXIS_W-1:0];
            REG_OFFSET_Y: offset_y_ff <= csr_wr_data[AXIS_W-1:0];
            REG_OFFSET_Z: offset_z_ff <= csr_wr_data[AXIS_W-1:0];
            default:      ;
         endcase
      end
   end

   asm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .scale     (scale_ff),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .offset_z  (offset_z_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   assign req_stall = !front_ready;

   // root cell chain
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      asm_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // last cell is the output register
   assign chain_ready[CELLS]  = !rsp_stall;
   assign rsp_valid           = chain_valid[CELLS];
   assign rsp_data.accel_x    = chain_data[CELLS].ax;
   assign rsp_data.accel_y    = chain_data[CELLS].ay;
   assign rsp_data.accel_z    = chain_data[CELLS].az;
   assign rsp_data.magnitude  = chain_data[CELLS].root;

endmodule : accel_sample_scale_magnitude
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerometer scale and magnitude block.
// Bursts queued by the stimulus process are offered by a driver on the
// falling edge. The expected axes and magnitude are worked out when each
// burst is taken, and every returned transaction is checked in order. Both
// sides idle at random. The receiver holds off once for a long stretch, and
// the scale and offset registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
   import asm_pkg::*;

   localparam int IDLE_PCT   = 19;
   localparam int HOLD_LEN   = 150;
   localparam int HOLD_AT    = 500;
   localparam int STALL_MAX  = 2000;
   localparam int PHASE_RAND = 275;
   localparam int DRAIN_WAIT = 40;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [IDX_W-1:0]    csr_index   = REG_SCALE;
   logic [CSR_W-1:0]    csr_wr_data = '0;

   // register copy used for prediction
   logic [SCALE_W-1:0]       cfg_scale = SCALE_RESET;
   logic signed [AXIS_W-1:0] cfg_offset [3] = '{default: '0};

   req_type pending_bursts [$];
   rsp_type expected_samples [$];
   logic    burst_taken  = 1'b0;
   bit      steady       = 1'b0;
   bit      hold_armed   = 1'b1;
   int      hold_left    = 0;
   int      results_seen = 0;
   int      fault_count  = 0;
   int      quiet_cycles = 0;

   accel_sample_scale_magnitude dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // scaled, offset and clamped axis in Q8
   function automatic logic signed [AXIS_W-1:0] axis_q8(logic [7:0] lo, logic [7:0] hi,
                                                         logic [SCALE_W-1:0] scale,
                                                         logic signed [AXIS_W-1:0] off);
      longint count;
      longint v;
      count = longint'($signed({hi, lo}));
      v = ((count * longint'({1'b0, scale})) >>> 8) - longint'(off);
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[AXIS_W-1:0];
   endfunction

   // floor of the square root, one root bit at a time from the top
   function automatic logic [AXIS_W-1:0] root_floor(logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = AXIS_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root[AXIS_W-1:0];
   endfunction

   function automatic rsp_type predict_sample(req_type b);
      rsp_type r;
      longint  sx;
      longint  sy;
      longint  sz;
      r.accel_x = axis_q8(b.x_low, b.x_high, cfg_scale, cfg_offset[0]);
      r.accel_y = axis_q8(b.y_low, b.y_high, cfg_scale, cfg_offset[1]);
      r.accel_z = axis_q8(b.z_low, b.z_high, cfg_scale, cfg_offset[2]);
      sx = longint'(r.accel_x);
      sy = longint'(r.accel_y);
      sz = longint'(r.accel_z);
      r.magnitude = root_floor(64'(sx * sx + sy * sy + sz * sz));
      return r;
   endfunction

   function automatic req_type burst_of(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_type b;
      b.x_low  = x[7:0];
      b.x_high = x[15:8];
      b.y_low  = y[7:0];
      b.y_high = y[15:8];
      b.z_low  = z[7:0];
      b.z_high = z[15:8];
      return b;
   endfunction

   // full-scale counts are favoured now and then so clamping is reached
   function automatic logic [15:0] random_count();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_directed();
      pending_bursts.push_back(burst_of(16'h0000, 16'h0000, 16'h0000));
      pending_bursts.push_back(burst_of(16'h7FFF, 16'h7FFF, 16'h7FFF));
      pending_bursts.push_back(burst_of(16'h8000, 16'h8000, 16'h8000));
      pending_bursts.push_back(burst_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_bursts.push_back(burst_of(16'h0001, 16'h0001, 16'h0001));
      pending_bursts.push_back(burst_of(16'h7FFF, 16'h8000, 16'h0000));
      pending_bursts.push_back(burst_of(16'h8000, 16'h0000, 16'h7FFF));
      pending_bursts.push_back(burst_of(16'h0000, 16'h7FFF, 16'h8000));
      pending_bursts.push_back(burst_of(16'h00FF, 16'hFF00, 16'h0100));
      pending_bursts.push_back(burst_of(16'h1234, 16'hABCD, 16'h5A5A));
      pending_bursts.push_back(burst_of(16'hFF80, 16'h007F, 16'h8001));
      pending_bursts.push_back(burst_of(16'hFFFE, 16'h0002, 16'h4000));
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         pending_bursts.push_back(burst_of(random_count(), random_count(), random_count()));
      end
   endtask

   // hold the sender until every queued transaction has come back
   task automatic drain();
      while (pending_bursts.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic write_all(logic [CSR_W-1:0] scale, logic [CSR_W-1:0] ox,
                            logic [CSR_W-1:0] oy, logic [CSR_W-1:0] oz);
      write_reg(REG_SCALE, scale);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_OFFSET_Z, oz);
   endtask

   // stimulus: reset, then one phase per register setting
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values
      queue_directed();
      queue_random(PHASE_RAND);
      drain();

      // full scale against extreme offsets, clamps both ways
      write_all(24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
      queue_directed();
      queue_random(PHASE_RAND);
      drain();

      // zero scale, stray bits above the scale width
      write_all({8'($urandom) | 8'h01, 16'h0000}, 24'($urandom), 24'($urandom),
                24'($urandom));
      queue_random(PHASE_RAND);
      drain();

      write_all(24'($urandom), 24'($urandom_range(0, 4095)) - 24'd2048,
                24'($urandom_range(0, 4095)) - 24'd2048, 24'($urandom));
      queue_random(PHASE_RAND);
      drain();

      // smallest non-zero scale
      write_all(24'h000001, 24'h7FFFFF, 24'h800000, 24'h000000);
      queue_random(PHASE_RAND);
      drain();

      // no idling on either side
      write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      steady = 1'b1;
      queue_random(PHASE_RAND);
      drain();
      steady = 1'b0;

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // driver: hold an offered burst until taken, then offer the next or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !burst_taken) begin
         req_valid <= 1'b1;
      end else if (pending_bursts.size() != 0 &&
                   (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_valid <= 1'b1;
         req_data  <= pending_bursts.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stall, plus one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (hold_armed && results_seen >= HOLD_AT) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // monitor: track registers, predict taken bursts, check results
   always @(posedge clock) begin
      rsp_type want;
      bit      active;
      active = 1'b0;
      burst_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (csr_wr_en) begin
            active = 1'b1;
            case (csr_index)
               REG_SCALE:    cfg_scale     <= csr_wr_data[SCALE_W-1:0];
               REG_OFFSET_X: cfg_offset[0] <= $signed(csr_wr_data);
               REG_OFFSET_Y: cfg_offset[1] <= $signed(csr_wr_data);
               REG_OFFSET_Z: cfg_offset[2] <= $signed(csr_wr_data);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            active = 1'b1;
            expected_samples.push_back(predict_sample(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            active = 1'b1;
            results_seen <= results_seen + 1;
            if (expected_samples.size() == 0) begin
               fault_count <= fault_count + 1;
               if (fault_count < 10) begin
                  $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d m=%0d",
                           $realtime, rsp_data.accel_x, rsp_data.accel_y,
                           rsp_data.accel_z, rsp_data.magnitude);
               end
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.accel_x !== want.accel_x || rsp_data.accel_y !== want.accel_y ||
                   rsp_data.accel_z !== want.accel_z ||
                   rsp_data.magnitude !== want.magnitude) begin
                  fault_count <= fault_count + 1;
                  if (fault_count < 10) begin
                     $display("%0t: mismatch exp x=%0d y=%0d z=%0d m=%0d got x=%0d y=%0d z=%0d m=%0d",
                              $realtime, want.accel_x, want.accel_y, want.accel_z,
                              want.magnitude, rsp_data.accel_x, rsp_data.accel_y,
                              rsp_data.accel_z, rsp_data.magnitude);
                  end
               end
            end
         end
      end
      // watchdog on cycles with no transaction of any kind
      if (active || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule : tb
